// ----- hdl/rv32d_pkg.sv -----
// Shared opcodes, instruction kind codes and types for the RV32 instruction decoder.
`timescale 1ns / 1ps

package rv32d_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned ImmWidth   = 32;
  localparam int unsigned KindWidth  = 6;

  // Major opcodes, instruction bits 6 to 0.
  localparam logic [6:0] OP_OP      = 7'h33;
  localparam logic [6:0] OP_OP_IMM  = 7'h13;
  localparam logic [6:0] OP_LOAD    = 7'h03;
  localparam logic [6:0] OP_STORE   = 7'h23;
  localparam logic [6:0] OP_LOAD_FP = 7'h07;
  localparam logic [6:0] OP_STORE_FP = 7'h27;
  localparam logic [6:0] OP_OP_FP   = 7'h53;
  localparam logic [6:0] OP_BRANCH  = 7'h63;
  localparam logic [6:0] OP_JAL     = 7'h6F;
  localparam logic [6:0] OP_JALR    = 7'h67;
  localparam logic [6:0] OP_LUI     = 7'h37;
  localparam logic [6:0] OP_AUIPC   = 7'h17;

  typedef enum logic [KindWidth-1:0] {
    KIND_INVALID = 6'd0,
    KIND_ADD, KIND_SUB, KIND_AND, KIND_OR, KIND_XOR,
    KIND_SLL, KIND_SRL, KIND_SRA, KIND_SLT, KIND_SLTU,
    KIND_ADDI, KIND_ANDI, KIND_ORI, KIND_XORI, KIND_SLLI,
    KIND_SRLI, KIND_SRAI, KIND_SLTI, KIND_SLTIU,
    KIND_LW, KIND_SW, KIND_FLW, KIND_FSW,
    KIND_FADD_S, KIND_FSUB_S, KIND_FMUL_S, KIND_FDIV_S,
    KIND_BEQ, KIND_BNE, KIND_BLT, KIND_BGE, KIND_BLTU, KIND_BGEU,
    KIND_JAL, KIND_JALR, KIND_LUI, KIND_AUIPC
  } kind_e;

  typedef logic [InstrWidth-1:0] instr_t;
  typedef logic [ImmWidth-1:0]   imm_t;

endpackage

// ----- hdl/rv32_instruction_decoder.sv -----
// Top level of the RV32 instruction decoder: input register, decode logic, result register.
`timescale 1ns / 1ps
// Path: an accepted input word is held in the input register, decoded, then held in the result register.
// Throughput: one transaction per cycle; the input register and the result register each
// advance whenever the stage after them is empty or being drained.
// Reset: rst_ni clears both valid flags asynchronously; the payload registers are not reset.

module rv32_instruction_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Slave side: tdata = instruction_word[31:0].
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [31:0]         s_axis_tdata_i,
  // Master side: tdata = major_opcode[6:0], dest_reg[11:7], func3_field[14:12],
  // src1_reg[19:15], src2_reg[24:20], func7_field[31:25], immediate[63:32].
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [63:0]         m_axis_tdata_o,
  // tuser = kind[5:0].
  output logic [5:0]          m_axis_tuser_o
);
  import rv32d_pkg::*;

  // Stage one holds the raw word; stage two holds the decoded result.
  logic   in_valid_q;
  instr_t in_word_q;
  logic   out_valid_q;
  instr_t out_word_q;
  imm_t   out_imm_q;
  kind_e  out_kind_q;

  logic   out_en;
  logic   in_en;
  kind_e  dec_kind;
  imm_t   dec_imm;

  // The result register takes a new value when it is empty or its result is
  // being taken in this cycle; the input register follows the same rule one step back.
  assign out_en          = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || out_en;
  assign in_en           = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
      if (out_en) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_en) in_word_q <= s_axis_tdata_i;
    if (out_en && in_valid_q) begin
      out_word_q <= in_word_q;
      out_imm_q  <= dec_imm;
      out_kind_q <= dec_kind;
    end
  end

  rv32d_kind_dec u_kind_dec (
    .instr_i (in_word_q),
    .kind_o  (dec_kind)
  );

  rv32d_imm_gen u_imm_gen (
    .instr_i (in_word_q),
    .imm_o   (dec_imm)
  );

  // The register and function fields sit at their native bit positions, so the
  // low half of the result is the instruction word itself.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_imm_q, out_word_q};
  assign m_axis_tuser_o  = out_kind_q;

  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_en |=> m_axis_tvalid_o)
    else $error("decoded word did not reach the result register");

  a_full_pipe_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_en |-> !s_axis_tready_o)
    else $error("input accepted while both stages are full and stalled");

  a_rtype_no_imm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[6:0] == OP_OP || m_axis_tdata_o[6:0] == OP_OP_FP)
    |-> m_axis_tdata_o[63:32] == '0)
    else $error("register-register result carries a nonzero immediate");

  a_upper_imm_low_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[6:0] == OP_LUI || m_axis_tdata_o[6:0] == OP_AUIPC)
    |-> m_axis_tdata_o[43:32] == '0)
    else $error("upper immediate has nonzero low bits");

  a_jal_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[6:0] == OP_JAL |-> m_axis_tuser_o == KIND_JAL)
    else $error("jump opcode decoded to the wrong kind");

endmodule

// ----- hdl/rv32d_kind_dec.sv -----
// Classifies an instruction word into its kind code.
`timescale 1ns / 1ps

module rv32d_kind_dec (
  input  rv32d_pkg::instr_t instr_i,
  output rv32d_pkg::kind_e  kind_o
);
  import rv32d_pkg::*;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_JALR = 3'd0;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_FADD = 7'h00;
  localparam logic [6:0] F7_FSUB = 7'h04;
  localparam logic [6:0] F7_FMUL = 7'h08;
  localparam logic [6:0] F7_FDIV = 7'h0C;

  logic [6:0] opcode;
  logic [2:0] f3;
  logic [6:0] f7;

  assign opcode = instr_i[6:0];
  assign f3     = instr_i[14:12];
  assign f7     = instr_i[31:25];

  always_comb begin
    kind_o = KIND_INVALID;
    unique case (opcode)
      OP_OP: begin
        if (f7 == F7_BASE) begin
          unique case (f3)
            F3_ADD:  kind_o = KIND_ADD;
            F3_SLL:  kind_o = KIND_SLL;
            F3_SLT:  kind_o = KIND_SLT;
            F3_SLTU: kind_o = KIND_SLTU;
            F3_XOR:  kind_o = KIND_XOR;
            F3_SRL:  kind_o = KIND_SRL;
            F3_OR:   kind_o = KIND_OR;
            F3_AND:  kind_o = KIND_AND;
            default: kind_o = KIND_INVALID;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) kind_o = KIND_SUB;
          else if (f3 == F3_SRL) kind_o = KIND_SRA;
        end
      end
      OP_OP_IMM: begin
        unique case (f3)
          F3_ADD:  kind_o = KIND_ADDI;
          F3_AND:  kind_o = KIND_ANDI;
          F3_OR:   kind_o = KIND_ORI;
          F3_XOR:  kind_o = KIND_XORI;
          F3_SLL:  if (f7 == F7_BASE) kind_o = KIND_SLLI;
          F3_SRL: begin
            if (f7 == F7_BASE) kind_o = KIND_SRLI;
            else if (f7 == F7_ALT) kind_o = KIND_SRAI;
          end
          F3_SLT:  kind_o = KIND_SLTI;
          F3_SLTU: kind_o = KIND_SLTIU;
          default: kind_o = KIND_INVALID;
        endcase
      end
      OP_LOAD:     if (f3 == F3_WORD) kind_o = KIND_LW;
      OP_STORE:    if (f3 == F3_WORD) kind_o = KIND_SW;
      OP_LOAD_FP:  if (f3 == F3_WORD) kind_o = KIND_FLW;
      OP_STORE_FP: if (f3 == F3_WORD) kind_o = KIND_FSW;
      OP_OP_FP: begin
        // The rounding mode in func3 is not checked.
        if (f7 == F7_FADD) kind_o = KIND_FADD_S;
        else if (f7 == F7_FSUB) kind_o = KIND_FSUB_S;
        else if (f7 == F7_FMUL) kind_o = KIND_FMUL_S;
        else if (f7 == F7_FDIV) kind_o = KIND_FDIV_S;
      end
      OP_BRANCH: begin
        unique case (f3)
          F3_BEQ:  kind_o = KIND_BEQ;
          F3_BNE:  kind_o = KIND_BNE;
          F3_BLT:  kind_o = KIND_BLT;
          F3_BGE:  kind_o = KIND_BGE;
          F3_BLTU: kind_o = KIND_BLTU;
          F3_BGEU: kind_o = KIND_BGEU;
          default: kind_o = KIND_INVALID;
        endcase
      end
      OP_JAL:   kind_o = KIND_JAL;
      OP_JALR:  if (f3 == F3_JALR) kind_o = KIND_JALR;
      OP_LUI:   kind_o = KIND_LUI;
      OP_AUIPC: kind_o = KIND_AUIPC;
      default:  kind_o = KIND_INVALID;
    endcase
  end

endmodule

// ----- hdl/rv32d_imm_gen.sv -----
// Builds the sign-extended immediate for the format that the major opcode selects.
`timescale 1ns / 1ps

module rv32d_imm_gen (
  input  rv32d_pkg::instr_t instr_i,
  output rv32d_pkg::imm_t   imm_o
);
  import rv32d_pkg::*;

  imm_t imm_i_fmt;
  imm_t imm_s_fmt;
  imm_t imm_b_fmt;
  imm_t imm_j_fmt;
  imm_t imm_u_fmt;

  assign imm_i_fmt = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s_fmt = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b_fmt = {{20{instr_i[31]}}, instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
  assign imm_j_fmt = {{12{instr_i[31]}}, instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
  assign imm_u_fmt = {instr_i[31:12], 12'h000};

  always_comb begin
    unique case (instr_i[6:0])
      OP_OP_IMM, OP_LOAD, OP_LOAD_FP, OP_JALR: imm_o = imm_i_fmt;
      OP_STORE, OP_STORE_FP:                   imm_o = imm_s_fmt;
      OP_BRANCH:                               imm_o = imm_b_fmt;
      OP_JAL:                                  imm_o = imm_j_fmt;
      OP_LUI, OP_AUIPC:                        imm_o = imm_u_fmt;
      // Register-register integer and floating-point operations and unknown opcodes carry no immediate.
      default:                                 imm_o = '0;
    endcase
  end

endmodule

// ----- tb/rv32_instruction_decoder_tb.sv -----
// Self-checking testbench for the RV32 instruction decoder with random stream stalls.
`timescale 1ns / 1ps

module rv32_instruction_decoder_tb;
  import rv32d_pkg::*;

  // Function codes of the supported encodings, and of unsupported ones used as invalid cases.
  localparam logic [2:0] F3_ADD_SUB = 3'd0;
  localparam logic [2:0] F3_SLL     = 3'd1;
  localparam logic [2:0] F3_SLT     = 3'd2;
  localparam logic [2:0] F3_SLTU    = 3'd3;
  localparam logic [2:0] F3_XOR     = 3'd4;
  localparam logic [2:0] F3_SRL_SRA = 3'd5;
  localparam logic [2:0] F3_OR      = 3'd6;
  localparam logic [2:0] F3_AND     = 3'd7;
  localparam logic [2:0] F3_WORD    = 3'd2;
  localparam logic [2:0] F3_BYTE    = 3'd0;
  localparam logic [2:0] F3_JALR    = 3'd0;
  localparam logic [2:0] F3_BEQ     = 3'd0;
  localparam logic [2:0] F3_BNE     = 3'd1;
  localparam logic [2:0] F3_BRANCH_RSVD = 3'd2;
  localparam logic [2:0] F3_BLT     = 3'd4;
  localparam logic [2:0] F3_BGE     = 3'd5;
  localparam logic [2:0] F3_BLTU    = 3'd6;
  localparam logic [2:0] F3_BGEU    = 3'd7;
  localparam logic [6:0] F7_BASE    = 7'h00;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [6:0] F7_MULDIV  = 7'h01;
  localparam logic [6:0] F7_FADD    = 7'h00;
  localparam logic [6:0] F7_FSUB    = 7'h04;
  localparam logic [6:0] F7_FMUL    = 7'h08;
  localparam logic [6:0] F7_FDIV    = 7'h0C;
  localparam logic [6:0] F7_FSQRT   = 7'h2C;

  localparam int unsigned RandomWords  = 850;
  localparam int unsigned MaxReported  = 10;
  localparam int unsigned DrainCycles  = 6;

  // One decoded instruction as it leaves the master side.
  typedef struct packed {
    kind_e      kind;
    logic [6:0] opcode;
    logic [4:0] rd;
    logic [2:0] funct3;
    logic [4:0] rs1;
    logic [4:0] rs2;
    logic [6:0] funct7;
    imm_t       imm;
  } decoded_t;

  // Keeps the decodes still owed by the block, in acceptance order.
  class decode_scoreboard;
    decoded_t    pending_q[$];
    int unsigned errors;

    function decoded_t predict_decode(instr_t w);
      decoded_t   d;
      logic [11:0] imm_i;
      logic [11:0] imm_s;
      d.opcode = w[6:0];
      d.rd     = w[11:7];
      d.funct3 = w[14:12];
      d.rs1    = w[19:15];
      d.rs2    = w[24:20];
      d.funct7 = w[31:25];
      d.kind   = KIND_INVALID;
      d.imm    = '0;
      imm_i    = w[31:20];
      imm_s    = {w[31:25], w[11:7]};
      case (d.opcode)
        OP_OP: begin
          if (d.funct7 == F7_BASE) begin
            case (d.funct3)
              F3_ADD_SUB: d.kind = KIND_ADD;
              F3_SLL:     d.kind = KIND_SLL;
              F3_SLT:     d.kind = KIND_SLT;
              F3_SLTU:    d.kind = KIND_SLTU;
              F3_XOR:     d.kind = KIND_XOR;
              F3_SRL_SRA: d.kind = KIND_SRL;
              F3_OR:      d.kind = KIND_OR;
              default:    d.kind = KIND_AND;
            endcase
          end else if (d.funct7 == F7_ALT) begin
            if (d.funct3 == F3_ADD_SUB) d.kind = KIND_SUB;
            else if (d.funct3 == F3_SRL_SRA) d.kind = KIND_SRA;
          end
        end
        OP_OP_IMM: begin
          case (d.funct3)
            F3_ADD_SUB: d.kind = KIND_ADDI;
            F3_AND:     d.kind = KIND_ANDI;
            F3_OR:      d.kind = KIND_ORI;
            F3_XOR:     d.kind = KIND_XORI;
            F3_SLL:     if (d.funct7 == F7_BASE) d.kind = KIND_SLLI;
            F3_SRL_SRA: begin
              if (d.funct7 == F7_BASE) d.kind = KIND_SRLI;
              else if (d.funct7 == F7_ALT) d.kind = KIND_SRAI;
            end
            F3_SLT:     d.kind = KIND_SLTI;
            default:    d.kind = KIND_SLTIU;
          endcase
          d.imm = {{20{imm_i[11]}}, imm_i};
        end
        OP_LOAD: begin
          if (d.funct3 == F3_WORD) d.kind = KIND_LW;
          d.imm = {{20{imm_i[11]}}, imm_i};
        end
        OP_STORE: begin
          if (d.funct3 == F3_WORD) d.kind = KIND_SW;
          d.imm = {{20{imm_s[11]}}, imm_s};
        end
        OP_LOAD_FP: begin
          if (d.funct3 == F3_WORD) d.kind = KIND_FLW;
          d.imm = {{20{imm_i[11]}}, imm_i};
        end
        OP_STORE_FP: begin
          if (d.funct3 == F3_WORD) d.kind = KIND_FSW;
          d.imm = {{20{imm_s[11]}}, imm_s};
        end
        OP_OP_FP: begin
          // The rounding mode in funct3 plays no part in the kind.
          case (d.funct7)
            F7_FADD: d.kind = KIND_FADD_S;
            F7_FSUB: d.kind = KIND_FSUB_S;
            F7_FMUL: d.kind = KIND_FMUL_S;
            F7_FDIV: d.kind = KIND_FDIV_S;
            default: d.kind = KIND_INVALID;
          endcase
        end
        OP_BRANCH: begin
          case (d.funct3)
            F3_BEQ:  d.kind = KIND_BEQ;
            F3_BNE:  d.kind = KIND_BNE;
            F3_BLT:  d.kind = KIND_BLT;
            F3_BGE:  d.kind = KIND_BGE;
            F3_BLTU: d.kind = KIND_BLTU;
            F3_BGEU: d.kind = KIND_BGEU;
            default: d.kind = KIND_INVALID;
          endcase
          d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
        OP_JAL: begin
          d.kind = KIND_JAL;
          d.imm  = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        OP_JALR: begin
          if (d.funct3 == F3_JALR) d.kind = KIND_JALR;
          d.imm = {{20{imm_i[11]}}, imm_i};
        end
        OP_LUI: begin
          d.kind = KIND_LUI;
          d.imm  = {w[31:12], 12'h000};
        end
        OP_AUIPC: begin
          d.kind = KIND_AUIPC;
          d.imm  = {w[31:12], 12'h000};
        end
        default: d.kind = KIND_INVALID;
      endcase
      return d;
    endfunction

    function void note_instruction(instr_t w);
      pending_q.push_back(predict_decode(w));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MaxReported)
          $display("Mismatch in %s: expected 0x%08h, actual 0x%08h", name, want, got);
      end
    endfunction

    function void check_decode(logic [63:0] data, logic [5:0] kind);
      decoded_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= MaxReported)
          $display("Result with nothing outstanding: tdata 0x%016h, tuser 0x%02h", data, kind);
        return;
      end
      want = pending_q.pop_front();
      compare_field("kind", want.kind, kind);
      compare_field("opcode", want.opcode, data[6:0]);
      compare_field("rd", want.rd, data[11:7]);
      compare_field("funct3", want.funct3, data[14:12]);
      compare_field("rs1", want.rs1, data[19:15]);
      compare_field("rs2", want.rs2, data[24:20]);
      compare_field("funct7", want.funct7, data[31:25]);
      compare_field("immediate", want.imm, data[63:32]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [63:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;

  // When set, neither side inserts gaps, so back-to-back transactions are exercised.
  bit steady_flow = 1'b0;

  decode_scoreboard decodes;

  rv32_instruction_decoder uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int unsigned idle_cycles();
    return steady_flow ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic instr_t build_word(logic [6:0] op, logic [2:0] f3, logic [6:0] f7,
                                        logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  // Forces the opcode and function bits of a random word so that it decodes as the given kind.
  function automatic instr_t encode_kind(kind_e k, instr_t raw);
    instr_t     w;
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic       fix_f3;
    logic       fix_f7;
    w      = raw;
    f3     = raw[14:12];
    f7     = raw[31:25];
    fix_f3 = 1'b1;
    fix_f7 = 1'b0;
    case (k)
      KIND_ADD:    {op, f3, f7, fix_f7} = {OP_OP, F3_ADD_SUB, F7_BASE, 1'b1};
      KIND_SUB:    {op, f3, f7, fix_f7} = {OP_OP, F3_ADD_SUB, F7_ALT, 1'b1};
      KIND_AND:    {op, f3, f7, fix_f7} = {OP_OP, F3_AND, F7_BASE, 1'b1};
      KIND_OR:     {op, f3, f7, fix_f7} = {OP_OP, F3_OR, F7_BASE, 1'b1};
      KIND_XOR:    {op, f3, f7, fix_f7} = {OP_OP, F3_XOR, F7_BASE, 1'b1};
      KIND_SLL:    {op, f3, f7, fix_f7} = {OP_OP, F3_SLL, F7_BASE, 1'b1};
      KIND_SRL:    {op, f3, f7, fix_f7} = {OP_OP, F3_SRL_SRA, F7_BASE, 1'b1};
      KIND_SRA:    {op, f3, f7, fix_f7} = {OP_OP, F3_SRL_SRA, F7_ALT, 1'b1};
      KIND_SLT:    {op, f3, f7, fix_f7} = {OP_OP, F3_SLT, F7_BASE, 1'b1};
      KIND_SLTU:   {op, f3, f7, fix_f7} = {OP_OP, F3_SLTU, F7_BASE, 1'b1};
      KIND_ADDI:   {op, f3} = {OP_OP_IMM, F3_ADD_SUB};
      KIND_ANDI:   {op, f3} = {OP_OP_IMM, F3_AND};
      KIND_ORI:    {op, f3} = {OP_OP_IMM, F3_OR};
      KIND_XORI:   {op, f3} = {OP_OP_IMM, F3_XOR};
      KIND_SLLI:   {op, f3, f7, fix_f7} = {OP_OP_IMM, F3_SLL, F7_BASE, 1'b1};
      KIND_SRLI:   {op, f3, f7, fix_f7} = {OP_OP_IMM, F3_SRL_SRA, F7_BASE, 1'b1};
      KIND_SRAI:   {op, f3, f7, fix_f7} = {OP_OP_IMM, F3_SRL_SRA, F7_ALT, 1'b1};
      KIND_SLTI:   {op, f3} = {OP_OP_IMM, F3_SLT};
      KIND_SLTIU:  {op, f3} = {OP_OP_IMM, F3_SLTU};
      KIND_LW:     {op, f3} = {OP_LOAD, F3_WORD};
      KIND_SW:     {op, f3} = {OP_STORE, F3_WORD};
      KIND_FLW:    {op, f3} = {OP_LOAD_FP, F3_WORD};
      KIND_FSW:    {op, f3} = {OP_STORE_FP, F3_WORD};
      KIND_FADD_S: {op, f7, fix_f3, fix_f7} = {OP_OP_FP, F7_FADD, 1'b0, 1'b1};
      KIND_FSUB_S: {op, f7, fix_f3, fix_f7} = {OP_OP_FP, F7_FSUB, 1'b0, 1'b1};
      KIND_FMUL_S: {op, f7, fix_f3, fix_f7} = {OP_OP_FP, F7_FMUL, 1'b0, 1'b1};
      KIND_FDIV_S: {op, f7, fix_f3, fix_f7} = {OP_OP_FP, F7_FDIV, 1'b0, 1'b1};
      KIND_BEQ:    {op, f3} = {OP_BRANCH, F3_BEQ};
      KIND_BNE:    {op, f3} = {OP_BRANCH, F3_BNE};
      KIND_BLT:    {op, f3} = {OP_BRANCH, F3_BLT};
      KIND_BGE:    {op, f3} = {OP_BRANCH, F3_BGE};
      KIND_BLTU:   {op, f3} = {OP_BRANCH, F3_BLTU};
      KIND_BGEU:   {op, f3} = {OP_BRANCH, F3_BGEU};
      KIND_JAL:    {op, fix_f3} = {OP_JAL, 1'b0};
      KIND_JALR:   {op, f3} = {OP_JALR, F3_JALR};
      KIND_LUI:    {op, fix_f3} = {OP_LUI, 1'b0};
      default:     {op, fix_f3} = {OP_AUIPC, 1'b0};
    endcase
    w[6:0] = op;
    if (fix_f3) w[14:12] = f3;
    if (fix_f7) w[31:25] = f7;
    return w;
  endfunction

  function automatic logic [6:0] known_opcode(int unsigned idx);
    case (idx)
      0:       return OP_OP;
      1:       return OP_OP_IMM;
      2:       return OP_LOAD;
      3:       return OP_STORE;
      4:       return OP_LOAD_FP;
      5:       return OP_STORE_FP;
      6:       return OP_OP_FP;
      7:       return OP_BRANCH;
      8:       return OP_JAL;
      9:       return OP_JALR;
      10:      return OP_LUI;
      default: return OP_AUIPC;
    endcase
  endfunction

  // Offers one word on the slave side after a random gap and returns once it is accepted.
  // Valid stays high into the next word when that word has no gap.
  task automatic send_word(input instr_t w);
    int unsigned gap;
    gap = idle_cycles();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk_i); while (!s_axis_tready);
    decodes.note_instruction(w);
  endtask

  // Master side: stalls for a random number of cycles before each result, then takes it.
  task automatic collect_decodes();
    int unsigned stall;
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      decodes.check_decode(m_axis_tdata, m_axis_tuser);
    end
  endtask

  task automatic run_directed();
    send_word(32'h0000_0013);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    send_word(build_word(OP_OP, F3_ADD_SUB, F7_BASE, 5'd31, 5'd31, 5'd31));
    send_word(build_word(OP_OP, F3_ADD_SUB, F7_ALT, 5'd0, 5'd0, 5'd0));
    send_word(build_word(OP_OP, F3_SRL_SRA, F7_ALT, 5'($urandom), 5'($urandom), 5'($urandom)));
    // Multiply-divide encodings are not part of the subset.
    send_word(build_word(OP_OP, F3_AND, F7_MULDIV, 5'($urandom), 5'($urandom), 5'($urandom)));
    // Most negative and most positive I-format immediates.
    send_word(build_word(OP_OP_IMM, F3_ADD_SUB, 7'h40, 5'd7, 5'd3, 5'd0));
    send_word(build_word(OP_OP_IMM, F3_XOR, 7'h3F, 5'd1, 5'd2, 5'd31));
    send_word(build_word(OP_OP_IMM, F3_SRL_SRA, F7_ALT, 5'd5, 5'd6, 5'd17));
    // Shift-left immediate with a nonzero upper field is invalid but keeps its immediate.
    send_word(build_word(OP_OP_IMM, F3_SLL, F7_ALT, 5'd9, 5'd10, 5'd3));
    send_word(build_word(OP_OP_IMM, F3_SLTU, 7'h7F, 5'd11, 5'd12, 5'd31));
    send_word(build_word(OP_LOAD, F3_WORD, 7'h7F, 5'd13, 5'd14, 5'd31));
    send_word(build_word(OP_STORE, F3_WORD, 7'h40, 5'd0, 5'd15, 5'd16));
    send_word(build_word(OP_LOAD_FP, F3_WORD, 7'h00, 5'd18, 5'd19, 5'd1));
    send_word(build_word(OP_STORE_FP, F3_WORD, 7'h3F, 5'd31, 5'd20, 5'd21));
    send_word(build_word(OP_LOAD, F3_BYTE, 7'h55, 5'd22, 5'd23, 5'd24));
    // Floating-point kinds ignore the rounding-mode bits.
    send_word(build_word(OP_OP_FP, 3'($urandom), F7_FADD, 5'd1, 5'd2, 5'd3));
    send_word(build_word(OP_OP_FP, 3'($urandom), F7_FSUB, 5'd4, 5'd5, 5'd6));
    send_word(build_word(OP_OP_FP, 3'($urandom), F7_FMUL, 5'd7, 5'd8, 5'd9));
    send_word(build_word(OP_OP_FP, 3'($urandom), F7_FDIV, 5'd10, 5'd11, 5'd12));
    send_word(build_word(OP_OP_FP, F3_ADD_SUB, F7_FSQRT, 5'd13, 5'd14, 5'd0));
    // Branch with the most negative offset, then a reserved branch condition.
    send_word(build_word(OP_BRANCH, F3_BLTU, 7'h40, 5'd0, 5'd25, 5'd26));
    send_word(build_word(OP_BRANCH, F3_BRANCH_RSVD, 7'h3F, 5'd30, 5'd27, 5'd28));
    send_word({25'h1FF_FFFF, OP_JAL});
    send_word(build_word(OP_JALR, F3_SLL, 7'h12, 5'd29, 5'd30, 5'd31));
    send_word({20'hFFFFF, 5'd31, OP_LUI});
    send_word({20'h80001, 5'd2, OP_AUIPC});
  endtask

  // Mostly well-formed instructions with random operands; the rest have a known opcode with
  // random function bits, or are fully random words.
  task automatic run_random();
    int unsigned pick;
    instr_t      w;
    for (int unsigned i = 0; i < RandomWords; i++) begin
      steady_flow = ((i / 50) % 5) == 4;
      pick = $urandom_range(0, 99);
      w    = $urandom;
      if (pick < 80) begin
        w = encode_kind(kind_e'($urandom_range(1, 37)), w);
      end else if (pick < 95) begin
        w[6:0] = known_opcode($urandom_range(0, 11));
      end
      send_word(w);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    decodes = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      collect_decodes();
    join_none
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    while (decodes.pending_q.size() != 0) @(posedge clk_i);
    // Let any stray output show up after the last expected one.
    repeat (DrainCycles) @(posedge clk_i);
    if (decodes.errors == 0 && decodes.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rv32d_pkg.sv
hdl/rv32d_kind_dec.sv
hdl/rv32d_imm_gen.sv
hdl/rv32_instruction_decoder.sv
tb/rv32_instruction_decoder_tb.sv
